// ===== rtl/ppd_pkg.sv =====
// Shared types, constants and helper functions of the pedal plausibility controller.
`default_nettype none
package ppd_pkg;

  localparam int unsigned PW     = 15;  // calibration extreme width
  localparam int unsigned SPAN_W = 16;
  localparam int unsigned QW     = 7;   // percentage width
  localparam int unsigned NUM_W  = PW + QW;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned LIM_W  = 7;

  localparam logic [PW-1:0] MIN_RESET = 15'h7FFF;
  localparam logic [QW-1:0] PCT_FULL  = 7'd100;
  localparam int unsigned   SIXTH_MUL = 43691;  // 2^18 / 6, rounded up
  localparam int unsigned   SIXTH_SHR = 18;

  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_LIMIT  = 2'd1;

  typedef enum logic [2:0] {
    M_LV    = 3'd0,
    M_PRE   = 3'd1,
    M_HV    = 3'd2,
    M_DRIVE = 3'd3,
    M_FAULT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_LV_DRIVE = 3'd1,
    C_TIMEOUT  = 3'd2,
    C_NO_BRAKE = 3'd3,
    C_HV_OFF   = 3'd4,
    C_DISC     = 3'd5,
    C_BRAKE    = 3'd6
  } cause_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START0,
    ST_WAIT0,
    ST_START1,
    ST_WAIT1,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    mode_e  m;
    cause_e c;
  } mc_t;

  typedef struct packed {
    logic load;
    logic start;
    logic sel;
    logic capture;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_blocked;
  } status_t;

  function automatic mc_t go_mode(mc_t s, mode_e nm);
    mc_t r;
    r = s;
    if (s.m == M_FAULT && nm != M_FAULT) begin
      r.c = C_NONE;
    end
    r.m = nm;
    return r;
  endfunction

  function automatic mc_t raise_fault(mc_t s, cause_e c);
    mc_t r;
    r = go_mode(s, M_FAULT);
    r.c = c;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ppd_div.sv =====
// Restoring divider producing a percentage quotient one bit per cycle.
`default_nettype none
module ppd_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ppd_pkg::NUM_W-1:0] num_i,
  input  wire logic [ppd_pkg::PW-1:0]    den_i,
  output logic                           done_o,
  output logic [ppd_pkg::QW-1:0]         quot_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [ppd_pkg::NUM_W-1:0] rem_q, rem_d;
  logic [ppd_pkg::PW-1:0]    den_q, den_d;
  logic [ppd_pkg::QW-1:0]    quot_q, quot_d;
  logic [ppd_pkg::NUM_W-1:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    trial  = ppd_pkg::NUM_W'(den_q) << cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'(ppd_pkg::QW - 1);
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[cnt_q]  = 1'b1;
      end
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== rtl/ppd_datapath.sv =====
// Datapath: held samples, calibration, percentages, plausibility checks and mode registers.
`default_nettype none
module ppd_datapath #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ppd_pkg::cmd_t                     cmd_i,
  output ppd_pkg::status_t                       status_o,
  input  wire logic [SAMPLE_BITS-1:0]            throttle_a_i,
  input  wire logic [SAMPLE_BITS-1:0]            throttle_b_i,
  input  wire logic [SAMPLE_BITS-1:0]            brake_sample_i,
  input  wire logic                              hv_switch_i,
  input  wire logic                              drive_switch_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ppd_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              out_stall_i,
  output logic                                   out_valid_o,
  output logic [2:0]                             mode_o,
  output logic [2:0]                             fault_cause_o
);

  localparam int unsigned LVL_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam logic [LVL_W-1:0] LVL_RESET = LVL_W'((1 << SAMPLE_BITS) - 1 - 50);
  localparam int unsigned PW = ppd_pkg::PW;

  logic [LVL_W-1:0]           level_q;
  logic [ppd_pkg::LIM_W-1:0]  limit_q;

  ppd_pkg::mode_e             mode_q, smode_q;
  ppd_pkg::cause_e            cause_q, scause_q;
  logic                       first_q;
  logic [PW-1:0]              max_q [3];
  logic [PW-1:0]              min_q [3];
  logic [ppd_pkg::SPAN_W-1:0] span_q;
  logic [ppd_pkg::SPAN_W-1:0] sixth_q;
  logic [SAMPLE_BITS-1:0]     held_q [3];
  logic                       hv_q, drv_q;
  logic [ppd_pkg::QW-1:0]     pct_q [2];
  logic                       spec_q;
  logic [ppd_pkg::QW-1:0]     spec_val_q;
  logic                       out_valid_q;

  // Percentage set-up for the selected throttle sensor.
  logic [PW-1:0]              sel_mx, sel_mn, sel_c;
  logic signed [PW:0]         sel_den;
  logic                       start_spec;
  logic [ppd_pkg::QW-1:0]     start_spec_val;
  logic [ppd_pkg::NUM_W-1:0]  start_num;
  logic                       div_done;
  logic [ppd_pkg::QW-1:0]     div_quot;

  always_comb begin
    sel_mx  = max_q[{1'b0, cmd_i.sel}];
    sel_mn  = min_q[{1'b0, cmd_i.sel}];
    sel_c   = PW'(held_q[{1'b0, cmd_i.sel}]);
    sel_den = $signed({1'b0, sel_mx}) - $signed({1'b0, sel_mn});
    start_spec     = 1'b0;
    start_spec_val = '0;
    if (sel_den == '0) begin
      start_spec = 1'b1;
    end else if (sel_den < 0) begin
      // Inverted calibration: the clamp pins the sample at an extreme.
      start_spec = 1'b1;
      start_spec_val = (sel_c > sel_mx) ? ppd_pkg::PCT_FULL : '0;
    end else begin
      if (sel_c > sel_mx) begin
        sel_c = sel_mx;
      end else if (sel_c < sel_mn) begin
        sel_c = sel_mn;
      end
    end
    start_num = ppd_pkg::NUM_W'(sel_c - sel_mn) * ppd_pkg::NUM_W'(ppd_pkg::PCT_FULL);
  end

  ppd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   (start_num),
    .den_i   (sel_den[PW-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Samples are taken in every mode that checks the throttles or calibrates.
  logic take;
  always_comb begin
    take = 1'b0;
    unique case (mode_q)
      ppd_pkg::M_LV:    take = !first_q;
      ppd_pkg::M_HV:    take = 1'b1;
      ppd_pkg::M_DRIVE: take = 1'b1;
      ppd_pkg::M_FAULT: take = (cause_q == ppd_pkg::C_HV_OFF) ||
                               (cause_q == ppd_pkg::C_DISC) ||
                               (cause_q == ppd_pkg::C_BRAKE);
      default:          take = 1'b0;
    endcase
  end

  // Checks on the held samples.
  logic signed [ppd_pkg::QW:0]  pdiff;
  logic [ppd_pkg::QW:0]         pabs;
  logic                         dis;
  logic [ppd_pkg::SPAN_W-1:0]   bval;
  logic [ppd_pkg::SPAN_W-1:0]   bmax, bmin;
  logic [ppd_pkg::SPAN_W+7:0]   bprod;
  logic                         pressed;
  logic [SAMPLE_BITS+1:0]       thr4;
  logic                         thr_gt, thr_ge;

  always_comb begin
    pdiff = $signed({1'b0, pct_q[0]}) - $signed({1'b0, pct_q[1]});
    pabs  = (pdiff < 0) ? $unsigned(-pdiff) : $unsigned(pdiff);
    dis   = pabs > {1'b0, limit_q};
    bmax  = ppd_pkg::SPAN_W'(max_q[2]);
    bmin  = ppd_pkg::SPAN_W'(min_q[2]);
    bval  = ppd_pkg::SPAN_W'(held_q[2]) - sixth_q;
    if (bval > bmax) begin
      bval = bmax;
    end
    if (bval < bmin) begin
      bval = bmin;
    end
    bprod   = (ppd_pkg::SPAN_W+8)'(bval - bmin) * (ppd_pkg::SPAN_W+8)'(ppd_pkg::PCT_FULL);
    pressed = (span_q != '0) && (bprod >= (ppd_pkg::SPAN_W+8)'(span_q));
    thr4    = {held_q[0], 2'b00};
    thr_gt  = 32'(thr4) > 32'(span_q);
    thr_ge  = 32'(thr4) >= 32'(span_q);
  end

  // Mode decision for one pass, checks in their fixed order.
  ppd_pkg::mc_t     s;
  ppd_pkg::mode_e   smode_d;
  ppd_pkg::cause_e  scause_d;
  logic             first_d;
  logic [PW-1:0]    max_d [3];
  logic [PW-1:0]    min_d [3];
  logic [ppd_pkg::SPAN_W-1:0] span_d;
  logic             bad;

  always_comb begin
    s        = '{m: mode_q, c: cause_q};
    smode_d  = smode_q;
    scause_d = scause_q;
    first_d  = first_q;
    max_d    = max_q;
    min_d    = min_q;
    span_d   = span_q;
    bad      = 1'b0;
    unique case (mode_q)
      ppd_pkg::M_LV: begin
        if (first_q) begin
          for (int k = 0; k < 3; k++) begin
            max_d[k] = '0;
            min_d[k] = ppd_pkg::MIN_RESET;
          end
          first_d = 1'b0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (PW'(held_q[k]) > max_q[k]) max_d[k] = PW'(held_q[k]);
            if (PW'(held_q[k]) < min_q[k]) min_d[k] = PW'(held_q[k]);
          end
        end
        if (drv_q) begin
          s = ppd_pkg::raise_fault(s, ppd_pkg::C_LV_DRIVE);
        end else if (hv_q) begin
          span_d = ppd_pkg::SPAN_W'(max_d[0]) - ppd_pkg::SPAN_W'(min_d[0]);
          s = ppd_pkg::go_mode(s, ppd_pkg::M_PRE);
        end
      end
      ppd_pkg::M_PRE: begin
        s = ppd_pkg::go_mode(s, ppd_pkg::M_HV);
      end
      ppd_pkg::M_HV: begin
        if (s.c != ppd_pkg::C_DISC && dis) begin
          smode_d = s.m; scause_d = s.c;
          s = ppd_pkg::raise_fault(s, ppd_pkg::C_DISC);
        end
        if (!hv_q) begin
          s = ppd_pkg::go_mode(s, ppd_pkg::M_LV);
        end else if (drv_q) begin
          if (LVL_W'(held_q[2]) >= level_q) begin
            s = ppd_pkg::go_mode(s, ppd_pkg::M_DRIVE);
          end else begin
            s = ppd_pkg::raise_fault(s, ppd_pkg::C_NO_BRAKE);
          end
        end
      end
      ppd_pkg::M_DRIVE: begin
        if (s.c != ppd_pkg::C_DISC && dis) begin
          smode_d = s.m; scause_d = s.c;
          s = ppd_pkg::raise_fault(s, ppd_pkg::C_DISC);
        end
        bad = (s.m == ppd_pkg::M_FAULT && s.c == ppd_pkg::C_BRAKE) ? thr_ge
                                                                    : (pressed && thr_gt);
        if (!drv_q) begin
          s = ppd_pkg::go_mode(s, ppd_pkg::M_HV);
        end else if (!hv_q) begin
          s = ppd_pkg::raise_fault(s, ppd_pkg::C_HV_OFF);
        end else if (bad) begin
          s = ppd_pkg::raise_fault(s, ppd_pkg::C_BRAKE);
        end
      end
      ppd_pkg::M_FAULT: begin
        unique case (cause_q)
          ppd_pkg::C_LV_DRIVE: begin
            if (!drv_q) s = ppd_pkg::go_mode(s, ppd_pkg::M_LV);
          end
          ppd_pkg::C_TIMEOUT: begin
            if (!hv_q && !drv_q) s = ppd_pkg::go_mode(s, ppd_pkg::M_LV);
          end
          ppd_pkg::C_NO_BRAKE: begin
            if (!drv_q) s = ppd_pkg::go_mode(s, ppd_pkg::M_HV);
          end
          ppd_pkg::C_HV_OFF: begin
            if (dis) begin
              smode_d = s.m; scause_d = s.c;
              s = ppd_pkg::raise_fault(s, ppd_pkg::C_DISC);
            end
            if (!drv_q) s = ppd_pkg::go_mode(s, ppd_pkg::M_LV);
          end
          ppd_pkg::C_DISC: begin
            if (!dis) begin
              if (smode_q == ppd_pkg::M_FAULT) begin
                s = ppd_pkg::raise_fault(s, scause_q);
              end else begin
                s = ppd_pkg::go_mode(s, smode_q);
              end
            end
          end
          ppd_pkg::C_BRAKE: begin
            if (dis) begin
              smode_d = s.m; scause_d = s.c;
              s = ppd_pkg::raise_fault(s, ppd_pkg::C_DISC);
            end
            bad = (s.m == ppd_pkg::M_FAULT && s.c == ppd_pkg::C_BRAKE) ? thr_ge
                                                                        : (pressed && thr_gt);
            if (!bad) s = ppd_pkg::go_mode(s, ppd_pkg::M_DRIVE);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LVL_RESET;
      limit_q     <= ppd_pkg::LIM_W'(10);
      mode_q      <= ppd_pkg::M_LV;
      cause_q     <= ppd_pkg::C_NONE;
      smode_q     <= ppd_pkg::M_LV;
      scause_q    <= ppd_pkg::C_NONE;
      first_q     <= 1'b1;
      span_q      <= '0;
      sixth_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        max_q[k]  <= '0;
        held_q[k] <= '0;
      end
      min_q[0] <= ppd_pkg::MIN_RESET;
      min_q[1] <= ppd_pkg::MIN_RESET;
      min_q[2] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == ppd_pkg::REG_BRAKE_LEVEL) begin
          level_q <= LVL_W'(cfg_data_i);
        end else if (cfg_index_i == ppd_pkg::REG_DISC_LIMIT) begin
          limit_q <= cfg_data_i[ppd_pkg::LIM_W-1:0];
        end
      end
      // The span changes only on leaving low voltage, long before it is needed.
      sixth_q <= ppd_pkg::SPAN_W'((32'(span_q) * 32'(ppd_pkg::SIXTH_MUL)) >>
                                  ppd_pkg::SIXTH_SHR);
      if (cmd_i.load && take) begin
        held_q[0] <= throttle_a_i;
        held_q[1] <= throttle_b_i;
        held_q[2] <= brake_sample_i;
      end
      if (cmd_i.decide) begin
        mode_q   <= s.m;
        cause_q  <= s.c;
        smode_q  <= smode_d;
        scause_q <= scause_d;
        first_q  <= first_d;
        max_q    <= max_d;
        min_q    <= min_d;
        span_q   <= span_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hv_q  <= hv_switch_i;
      drv_q <= drive_switch_i;
    end
    if (cmd_i.start) begin
      spec_q     <= start_spec;
      spec_val_q <= start_spec_val;
    end
    if (cmd_i.capture) begin
      pct_q[cmd_i.sel] <= spec_q ? spec_val_q : div_quot;
    end
  end

  assign status_o.div_done    = div_done;
  assign status_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign mode_o        = mode_q;
  assign fault_cause_o = cause_q;

endmodule
`default_nettype wire

// ===== rtl/ppd_ctrl.sv =====
// Controller state machine sequencing one control-loop pass through the datapath.
`default_nettype none
module ppd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ppd_pkg::status_t    status_i,
  output ppd_pkg::cmd_t            cmd_o
);

  ppd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ppd_pkg::ST_IDLE);
    unique case (state_q)
      ppd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ppd_pkg::ST_START0;
        end
      end
      ppd_pkg::ST_START0: begin
        cmd_o.start = 1'b1;
        state_d     = ppd_pkg::ST_WAIT0;
      end
      ppd_pkg::ST_WAIT0: begin
        if (status_i.div_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ppd_pkg::ST_START1;
        end
      end
      ppd_pkg::ST_START1: begin
        cmd_o.sel   = 1'b1;
        cmd_o.start = 1'b1;
        state_d     = ppd_pkg::ST_WAIT1;
      end
      ppd_pkg::ST_WAIT1: begin
        cmd_o.sel = 1'b1;
        if (status_i.div_done) begin
          cmd_o.capture = 1'b1;
          state_d       = ppd_pkg::ST_DECIDE;
        end
      end
      ppd_pkg::ST_DECIDE: begin
        // The mode registers feed the output, so wait until the last result is taken.
        if (!status_i.out_blocked) begin
          cmd_o.decide = 1'b1;
          state_d      = ppd_pkg::ST_IDLE;
        end
      end
      default: state_d = ppd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pedal_plausibility_drive_fsm.sv =====
// Top level of the pedal plausibility and drive mode controller.
// Each input transaction is one control-loop pass: two throttle samples, a brake
// sample and the HV and drive switches. Each pass yields one result transaction
// carrying the new mode and fault cause.
// Both data channels use valid and stall; the configuration channel uses valid
// and ready, and ready is always high. Configuration is to be written by the
// user only while idle; the block itself does not enforce this.
// A pass runs from acceptance to a valid result through the load, two 7-step
// percentage divisions in the shared divider and the decision. A new pass is
// accepted once the previous one has reached its decision, so passes do not overlap.
// If the receiver stalls, the result is held and a following pass waits at its
// decision cycle until the result has been taken.
// Reset puts the block in low voltage with no fault, clears the calibration and
// restores the register defaults.
`default_nettype none
module pedal_plausibility_drive_fsm #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]        throttle_a_i,
  input  wire logic [SAMPLE_BITS-1:0]        throttle_b_i,
  input  wire logic [SAMPLE_BITS-1:0]        brake_sample_i,
  input  wire logic                          hv_switch_i,
  input  wire logic                          drive_switch_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         mode_o,
  output logic [2:0]                         fault_cause_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ppd_pkg::CFG_W-1:0]     cfg_data_i
);

  ppd_pkg::cmd_t    cmd;
  ppd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ppd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .throttle_a_i   (throttle_a_i),
    .throttle_b_i   (throttle_b_i),
    .brake_sample_i (brake_sample_i),
    .hv_switch_i    (hv_switch_i),
    .drive_switch_i (drive_switch_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .mode_o         (mode_o),
    .fault_cause_o  (fault_cause_o)
  );

endmodule
`default_nettype wire
